FILE: rtl/core/windowed_throughput_meter_core_defines.svh
// ----------------------------------------------------------------------------
// windowed throughput meter - assertion macros
// shared assertion helpers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef WINDOWED_THROUGHPUT_METER_CORE_DEFINES_SVH
`define WINDOWED_THROUGHPUT_METER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/core/wtm_pkg.sv
// ----------------------------------------------------------------------------
// wtm_pkg
// shared types and constants of the windowed throughput meter
// ----------------------------------------------------------------------------
package wtm_pkg;

    localparam int TIME_W        = 32;
    localparam int RATE_W        = 32;
    localparam int ACT_W         = 8;
    localparam int HOURS_W       = 21;
    localparam int MINSEC_W      = 6;
    localparam int WARMUP_W      = 8;
    localparam int MUL_CONST_W   = 12;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;

    localparam logic [WARMUP_W-1:0] WARMUP_RESET = 8'd20;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HR,
        ST_HR_WAIT,
        ST_MIN,
        ST_MIN_WAIT,
        ST_SLOT,
        ST_SLOT_WAIT,
        ST_AVG_MUL,
        ST_AVG,
        ST_AVG_WAIT,
        ST_FILL,
        ST_RD,
        ST_RD_WAIT,
        ST_WIN_MUL,
        ST_WIN,
        ST_WIN_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

FILE: rtl/core/wtm_in_if.sv
// ----------------------------------------------------------------------------
// wtm_in_if
// update channel: elapsed time, completion count, worker count
// ----------------------------------------------------------------------------
interface wtm_in_if #(
    parameter int COUNT_WIDTH = 24
);
    import wtm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [TIME_W-1:0]      elapsed_seconds;
    logic [COUNT_WIDTH-1:0] done_count;
    logic [ACT_W-1:0]       active_workers;

    modport source (output valid, elapsed_seconds, done_count, active_workers, input ready);
    modport sink   (input valid, elapsed_seconds, done_count, active_workers, output ready);
endinterface

FILE: rtl/core/wtm_out_if.sv
// ----------------------------------------------------------------------------
// wtm_out_if
// result channel: split clock, average and windowed rates
// ----------------------------------------------------------------------------
interface wtm_out_if;
    import wtm_pkg::*;

    logic                valid;
    logic                ready;
    logic [MINSEC_W-1:0] clock_seconds;
    logic [MINSEC_W-1:0] clock_minutes;
    logic [HOURS_W-1:0]  clock_hours;
    logic [RATE_W-1:0]   average_rate;
    logic [RATE_W-1:0]   window_rate;
    logic [ACT_W-1:0]    active_out;

    modport source (output valid, clock_seconds, clock_minutes, clock_hours, average_rate,
                    window_rate, active_out, input ready);
    modport sink   (input valid, clock_seconds, clock_minutes, clock_hours, average_rate,
                    window_rate, active_out, output ready);
endinterface

FILE: rtl/core/wtm_ram.sv
// ----------------------------------------------------------------------------
// wtm_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module wtm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 600
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/wtm_div.sv
// ----------------------------------------------------------------------------
// wtm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "windowed_throughput_meter_core_defines.svh"

module wtm_div #(
    parameter int DIVIDEND_W = 36,
    parameter int DIVISOR_W  = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [DIVIDEND_W-1:0]       i_dividend,
    input  logic [DIVISOR_W-1:0]        i_divisor,
    output wtm_pkg::t_div_status        o_status,
    output logic [DIVIDEND_W-1:0]       o_quotient,
    output logic [DIVISOR_W-1:0]        o_remainder
);
    import wtm_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;
    logic [DIVIDEND_W-1:0] n_quo;
    logic [DIVISOR_W-1:0]  n_rem;

    // bring down the next dividend bit and try a subtract
    always_comb begin
        shifted = {r_rem, r_quo[DIVIDEND_W-1]};
        fits    = (shifted >= {1'b0, r_dvs});
        trial   = shifted - {1'b0, r_dvs};
        n_rem   = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        n_quo   = {r_quo[DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;
    assign o_remainder   = r_rem;

    `ASSERT_IMPLIES(a_done_not_busy, i_clk, i_rst_n, r_done, !r_busy, "done while busy")
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !r_busy, r_busy, "start not taken")
    `ASSERT_IMPLIES(a_done_after_busy, i_clk, i_rst_n, r_done, $past(r_busy), "done from idle")
endmodule

FILE: rtl/core/windowed_throughput_meter_core.sv
// ----------------------------------------------------------------------------
// windowed_throughput_meter_core
// splits elapsed time into h/m/s, keeps a ring of counts per second and
// reports the average and windowed completion rates per hour
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  i_in     | in  | valid / ready    | elapsed_seconds, done_count, active_workers
//  o_out    | out | valid / ready    | clock_*, average_rate, window_rate, active_out
//  cfg      | in  | i_cfg_we         | i_cfg_wdata = warmup_seconds
//
//  one update takes up to 5 divisions of a DW-bit dividend (DW = max(COUNT_WIDTH+12, 33)),
//  plus a ring fill of 1 to HISTORY_DEPTH entries, plus the sequencing states;
//  the shared divider and the single ram write port set this
//  after reset the ring is cleared one entry per cycle, all HISTORY_DEPTH entries,
//  with i_in.ready low; config writes are taken at any time
//  a finished result waits in the output register while the next beat is taken
// ----------------------------------------------------------------------------
`include "windowed_throughput_meter_core_defines.svh"

module windowed_throughput_meter_core #(
    parameter int HISTORY_DEPTH = 600,
    parameter int COUNT_WIDTH   = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    wtm_in_if.sink                         i_in,
    wtm_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [wtm_pkg::WARMUP_W-1:0]   i_cfg_wdata
);
    import wtm_pkg::*;

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int MUL_W  = COUNT_WIDTH + MUL_CONST_W;
    // at least one bit above the rate width so saturation can be seen
    localparam int DW     = (MUL_W > RATE_W) ? MUL_W : RATE_W + 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(HISTORY_DEPTH - 1);

    // control state
    t_state              r_state;
    t_state              n_state;
    logic [SLOT_W-1:0]   r_last_slot;
    logic                r_out_valid;
    logic [WARMUP_W-1:0] r_warmup;

    // working registers for the item in flight
    logic [TIME_W-1:0]      r_t;
    logic [COUNT_WIDTH-1:0] r_cnt;
    logic [ACT_W-1:0]       r_act;
    logic                   r_short;
    logic [SLOT_W-1:0]      r_slot;
    logic [HOURS_W-1:0]     r_hours;
    logic [MINSEC_W-1:0]    r_min;
    logic [MINSEC_W-1:0]    r_sec;
    logic [MUL_W-1:0]       r_prod;
    logic [COUNT_WIDTH-1:0] r_diff;
    logic [RATE_W-1:0]      r_avg;
    logic [RATE_W-1:0]      r_win;

    // output register
    logic [MINSEC_W-1:0] r_o_sec;
    logic [MINSEC_W-1:0] r_o_min;
    logic [HOURS_W-1:0]  r_o_hours;
    logic [RATE_W-1:0]   r_o_avg;
    logic [RATE_W-1:0]   r_o_win;
    logic [ACT_W-1:0]    r_o_act;

    // shared divider
    logic                div_start;
    logic [DW-1:0]       div_dividend;
    logic [TIME_W-1:0]   div_divisor;
    t_div_status         div_status;
    logic [DW-1:0]       div_quo;
    logic [TIME_W-1:0]   div_rem;
    logic [RATE_W-1:0]   div_sat;
    logic                div_wait;

    // ring memory
    logic                   ram_we;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic [SLOT_W-1:0]      ram_raddr;
    logic [COUNT_WIDTH-1:0] ram_rdata;

    logic                   in_accept;
    logic                   out_free;
    logic                   slot_end;
    logic [SLOT_W-1:0]      n_last_slot;
    logic [SLOT_W-1:0]      slot_after;
    logic [COUNT_WIDTH-1:0] mul_a;
    logic [MUL_W-1:0]       mul_p;
    logic                   past_warmup;
    logic                   at_warmup;
    logic                   win_ok;

    assign in_accept   = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign slot_end    = (r_last_slot == r_slot);
    assign n_last_slot = (r_last_slot == LAST_IDX) ? '0 : r_last_slot + SLOT_W'(1);
    assign slot_after  = (r_slot == LAST_IDX) ? '0 : r_slot + SLOT_W'(1);
    assign past_warmup = (r_t > TIME_W'(r_warmup));
    assign at_warmup   = (r_t >= TIME_W'(r_warmup));

    // states that wait on the divider
    assign div_wait = (r_state == ST_HR_WAIT) || (r_state == ST_MIN_WAIT) ||
                      (r_state == ST_SLOT_WAIT) || (r_state == ST_AVG_WAIT) ||
                      (r_state == ST_WIN_WAIT);

    // clamp a rate quotient to 32 bits
    assign div_sat = (|div_quo[DW-1:RATE_W]) ? '1 : div_quo[RATE_W-1:0];

    // one constant multiplier shared by both rates
    assign mul_a = (r_state == ST_WIN_MUL) ? r_diff : r_cnt;
    assign mul_p = MUL_W'(mul_a) * MUL_W'(SECS_PER_HOUR);

    // window rate only when out of warm-up, count did not drop and span is nonzero
    assign win_ok = at_warmup && (r_cnt >= ram_rdata) && !(r_short && (r_t == '0));

    wtm_div #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (TIME_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_status    (div_status),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    wtm_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_last_slot),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:     if (r_last_slot == LAST_IDX) n_state = ST_IDLE;
            ST_IDLE:      if (in_accept) n_state = ST_HR;
            ST_HR:        n_state = ST_HR_WAIT;
            ST_HR_WAIT:   if (div_status.done) n_state = ST_MIN;
            ST_MIN:       n_state = ST_MIN_WAIT;
            ST_MIN_WAIT:  if (div_status.done) n_state = ST_SLOT;
            ST_SLOT:      n_state = ST_SLOT_WAIT;
            ST_SLOT_WAIT: begin
                if (div_status.done) begin
                    n_state = past_warmup ? ST_AVG_MUL : ST_FILL;
                end
            end
            ST_AVG_MUL:   n_state = ST_AVG;
            ST_AVG:       n_state = ST_AVG_WAIT;
            ST_AVG_WAIT:  if (div_status.done) n_state = ST_FILL;
            ST_FILL:      if (slot_end) n_state = ST_RD;
            ST_RD:        n_state = ST_RD_WAIT;
            ST_RD_WAIT:   n_state = win_ok ? ST_WIN_MUL : ST_OUT;
            ST_WIN_MUL:   n_state = ST_WIN;
            ST_WIN:       n_state = ST_WIN_WAIT;
            ST_WIN_WAIT:  if (div_status.done) n_state = ST_OUT;
            ST_OUT:       if (out_free) n_state = ST_IDLE;
            default:      n_state = ST_CLEAR;
        endcase
    end

    // sequencer outputs
    always_comb begin
        div_start    = 1'b0;
        div_dividend = DW'(r_t);
        div_divisor  = TIME_W'(SECS_PER_HOUR);
        ram_we       = 1'b0;
        ram_wdata    = r_cnt;
        // oldest sample: slot 0 while the ring is still filling, else the slot ahead
        ram_raddr    = r_short ? '0 : slot_after;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            ST_HR: begin
                div_start = 1'b1;
            end
            ST_MIN: begin
                div_start    = 1'b1;
                div_dividend = DW'(div_rem);
                div_divisor  = TIME_W'(SECS_PER_MIN);
            end
            ST_SLOT: begin
                div_start   = 1'b1;
                div_divisor = TIME_W'(HISTORY_DEPTH);
            end
            ST_AVG: begin
                div_start    = 1'b1;
                div_dividend = DW'(r_prod);
                div_divisor  = r_t;
            end
            ST_FILL: begin
                ram_we = 1'b1;
            end
            ST_WIN: begin
                div_start    = 1'b1;
                div_dividend = DW'(r_prod);
                div_divisor  = r_short ? r_t : TIME_W'(HISTORY_DEPTH);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_last_slot <= '0;
            r_out_valid <= 1'b0;
            r_warmup    <= WARMUP_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_warmup <= i_cfg_wdata;
            end
            // clear sweep ends back at slot 0, fill walk ends on the new slot
            if ((r_state == ST_CLEAR) || ((r_state == ST_FILL) && !slot_end)) begin
                r_last_slot <= n_last_slot;
            end
            if ((r_state == ST_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_t     <= i_in.elapsed_seconds;
            r_cnt   <= i_in.done_count;
            r_act   <= i_in.active_workers;
            r_short <= (i_in.elapsed_seconds < TIME_W'(HISTORY_DEPTH));
            r_avg   <= '0;
            r_win   <= '0;
        end
        if ((r_state == ST_HR_WAIT) && div_status.done) begin
            r_hours <= div_quo[HOURS_W-1:0];
        end
        if ((r_state == ST_MIN_WAIT) && div_status.done) begin
            r_min <= div_quo[MINSEC_W-1:0];
            r_sec <= div_rem[MINSEC_W-1:0];
        end
        if ((r_state == ST_SLOT_WAIT) && div_status.done) begin
            r_slot <= div_rem[SLOT_W-1:0];
        end
        if ((r_state == ST_AVG_MUL) || (r_state == ST_WIN_MUL)) begin
            r_prod <= mul_p;
        end
        if ((r_state == ST_AVG_WAIT) && div_status.done) begin
            r_avg <= div_sat;
        end
        if (r_state == ST_RD_WAIT) begin
            r_diff <= r_cnt - ram_rdata;
        end
        if ((r_state == ST_WIN_WAIT) && div_status.done) begin
            r_win <= div_sat;
        end
        if ((r_state == ST_OUT) && out_free) begin
            r_o_sec   <= r_sec;
            r_o_min   <= r_min;
            r_o_hours <= r_hours;
            r_o_avg   <= r_avg;
            r_o_win   <= r_win;
            r_o_act   <= r_act;
        end
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.clock_seconds = r_o_sec;
    assign o_out.clock_minutes = r_o_min;
    assign o_out.clock_hours   = r_o_hours;
    assign o_out.average_rate  = r_o_avg;
    assign o_out.window_rate   = r_o_win;
    assign o_out.active_out    = r_o_act;

    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_accept, r_state == ST_HR, "beat not started")
    `ASSERT_IMPLIES(a_done_in_wait, i_clk, i_rst_n, div_status.done, div_wait, "divider result unused")
    `ASSERT_IMPLIES(a_ring_idx, i_clk, i_rst_n, ram_we, r_last_slot <= LAST_IDX, "ring index out of range")
    `ASSERT_IMPLIES(a_out_from_seq, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == ST_OUT, "stray result")
endmodule

FILE: sim/windowed_throughput_meter_core_tb.sv
// ----------------------------------------------------------------------------
// windowed_throughput_meter_core_tb
// drives update beats into the meter and checks every reading it returns
// a directed table covers the extremes of time and count, the warm-up
// bounds, saturation, a count that drops and time that runs backwards
// random phases follow under several warm-up settings; the model of the
// ring and both rates lives in the testbench, and both channels stall at random
// ----------------------------------------------------------------------------
module windowed_throughput_meter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wtm_pkg::*;

    localparam int HIST_DEPTH     = 600;
    localparam int COUNT_W        = 24;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SHOW_LIMIT     = 10;
    localparam int PHASES         = 4;
    localparam int PHASE_BEATS    = 100;
    localparam int DRAIN_CYCLES   = 20;
    localparam int NO_CHANGE      = -1;

    typedef struct packed {
        logic [MINSEC_W-1:0] clock_seconds;
        logic [MINSEC_W-1:0] clock_minutes;
        logic [HOURS_W-1:0]  clock_hours;
        logic [RATE_W-1:0]   average_rate;
        logic [RATE_W-1:0]   window_rate;
        logic [ACT_W-1:0]    active_out;
    } t_reading;

    typedef struct {
        int                 warmup;
        logic [TIME_W-1:0]  elapsed;
        logic [COUNT_W-1:0] count;
        logic [ACT_W-1:0]   active;
        bit                 typed;
        t_reading           want;
    } t_update_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [WARMUP_W-1:0] i_cfg_wdata;

    wtm_in_if #(.COUNT_WIDTH(COUNT_W)) upd_if ();
    wtm_out_if                          rd_if ();

    windowed_throughput_meter_core #(
        .HISTORY_DEPTH(HIST_DEPTH),
        .COUNT_WIDTH  (COUNT_W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (upd_if),
        .o_out      (rd_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // model of the meter state
    logic [COUNT_W-1:0]  ring_counts [HIST_DEPTH];
    int unsigned         ring_last;
    logic [WARMUP_W-1:0] warmup_cfg;

    t_reading    pending_readings [$];
    int unsigned fault_count;
    int unsigned quiet_cycles;
    bit          calm;

    // directed updates; readings are typed in only where obvious
    t_update_row update_table [19] = '{
        '{NO_CHANGE, 32'd0, 24'd0, 8'h00, 1'b1,
          '{6'd0, 6'd0, 21'd0, 32'd0, 32'd0, 8'h00}},
        '{NO_CHANGE, 32'd1, 24'hFFFFFF, 8'hFF, 1'b1,
          '{6'd1, 6'd0, 21'd0, 32'd0, 32'd0, 8'hFF}},
        // no warm-up: average saturates, window is flat
        '{0, 32'd1, 24'hFFFFFF, 8'h01, 1'b1,
          '{6'd1, 6'd0, 21'd0, 32'hFFFFFFFF, 32'd0, 8'h01}},
        // zero elapsed time, fill wraps the whole ring
        '{NO_CHANGE, 32'd0, 24'd5, 8'h02, 1'b1,
          '{6'd0, 6'd0, 21'd0, 32'd0, 32'd0, 8'h02}},
        '{NO_CHANGE, 32'd3599, 24'd100, 8'h03, 1'b1,
          '{6'd59, 6'd59, 21'd0, 32'd100, 32'd0, 8'h03}},
        // count drops below the oldest ring entry
        '{NO_CHANGE, 32'd3600, 24'd50, 8'h04, 1'b1,
          '{6'd0, 6'd0, 21'd1, 32'd50, 32'd0, 8'h04}},
        '{NO_CHANGE, 32'd3601, 24'd10050, 8'h05, 1'b0, '0},
        '{NO_CHANGE, 32'hFFFFFFFF, 24'hFFFFFF, 8'h5A, 1'b0, '0},
        // time runs backwards across the ring end
        '{NO_CHANGE, 32'd1, 24'd0, 8'hA5, 1'b1,
          '{6'd1, 6'd0, 21'd0, 32'd0, 32'd0, 8'hA5}},
        // both rates saturate
        '{NO_CHANGE, 32'd2, 24'hFFFFFF, 8'h0F, 1'b1,
          '{6'd2, 6'd0, 21'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'h0F}},
        // warm-up bounds at the largest setting
        '{255, 32'd254, 24'd7, 8'h10, 1'b1,
          '{6'd14, 6'd4, 21'd0, 32'd0, 32'd0, 8'h10}},
        '{NO_CHANGE, 32'd255, 24'd9, 8'h20, 1'b0, '0},
        '{NO_CHANGE, 32'd256, 24'd11, 8'h40, 1'b0, '0},
        '{NO_CHANGE, 32'd599, 24'd123456, 8'h80, 1'b0, '0},
        '{NO_CHANGE, 32'd600, 24'd123460, 8'h7F, 1'b0, '0},
        '{20, 32'd1234567, 24'd654321, 8'h33, 1'b0, '0},
        '{NO_CHANGE, 32'd1234568, 24'd654000, 8'hCC, 1'b0, '0},
        '{NO_CHANGE, 32'h80000000, 24'h800000, 8'hC3, 1'b0, '0},
        '{NO_CHANGE, 32'h7FFFFFFF, 24'h7FFFFF, 8'h3C, 1'b0, '0}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // completions per hour over span seconds, clipped to the rate width
    function automatic logic [RATE_W-1:0] rate_per_hour(input longint unsigned diff,
                                                        input longint unsigned span);
        longint unsigned q;
        if (span == 0) return '0;
        q = diff * SECS_PER_HOUR / span;
        return (q > 64'hFFFFFFFF) ? '1 : q[RATE_W-1:0];
    endfunction

    // advance the ring for one update and return the reading it yields
    function automatic t_reading predict_reading(input logic [TIME_W-1:0] t,
                                                 input logic [COUNT_W-1:0] cnt,
                                                 input logic [ACT_W-1:0] act);
        t_reading           r;
        int unsigned        slot;
        logic [COUNT_W-1:0] older;
        longint unsigned    span;
        slot            = t % HIST_DEPTH;
        r.clock_seconds = MINSEC_W'(t % SECS_PER_MIN);
        r.clock_minutes = MINSEC_W'((t / SECS_PER_MIN) % SECS_PER_MIN);
        r.clock_hours   = HOURS_W'(t / SECS_PER_HOUR);
        r.average_rate  = (t > warmup_cfg) ? rate_per_hour(cnt, t) : '0;
        r.active_out    = act;
        ring_counts[slot] = cnt;
        // skipped seconds take the current count, wrapping at the ring end
        while (ring_last != slot) begin
            ring_counts[ring_last] = cnt;
            ring_last = (ring_last + 1) % HIST_DEPTH;
        end
        r.window_rate = '0;
        if (t >= warmup_cfg) begin
            if (t < HIST_DEPTH) begin
                older = ring_counts[0];
                span  = t;
            end else begin
                older = ring_counts[(slot + 1) % HIST_DEPTH];
                span  = HIST_DEPTH;
            end
            if (ring_counts[slot] >= older)
                r.window_rate = rate_per_hour(ring_counts[slot] - older, span);
        end
        return r;
    endfunction

    // mostly short gaps, a few long ones, none in a calm phase
    function automatic int unsigned idle_len();
        int unsigned roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_update(input logic [TIME_W-1:0] t, input logic [COUNT_W-1:0] cnt,
                               input logic [ACT_W-1:0] act, input bit typed,
                               input t_reading want);
        int unsigned gap;
        t_reading    due;
        gap = idle_len();
        if (gap > 0) begin
            upd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        upd_if.valid           <= 1'b1;
        upd_if.elapsed_seconds <= t;
        upd_if.done_count      <= cnt;
        upd_if.active_workers  <= act;
        do @(posedge i_clk); while (upd_if.ready !== 1'b1);
        due = predict_reading(t, cnt, act);
        pending_readings.push_back(typed ? want : due);
    endtask

    task automatic wait_drained();
        upd_if.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    // warm-up changes only while the meter sits idle
    task automatic load_warmup(input logic [WARMUP_W-1:0] v);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        warmup_cfg = v;
    endtask

    // result side: random back-pressure
    initial begin
        int unsigned hold;
        hold = 0;
        rd_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                rd_if.ready <= 1'b0;
                hold--;
            end else begin
                rd_if.ready <= 1'b1;
                hold = idle_len();
            end
        end
    end

    // reading check and watchdog
    always @(posedge i_clk) begin
        t_reading seen;
        t_reading want;
        bit       beat;
        beat = (upd_if.valid === 1'b1 && upd_if.ready === 1'b1);
        if (i_rst_n === 1'b1 && rd_if.valid === 1'b1 && rd_if.ready === 1'b1) begin
            beat = 1'b1;
            seen = '{rd_if.clock_seconds, rd_if.clock_minutes, rd_if.clock_hours,
                     rd_if.average_rate, rd_if.window_rate, rd_if.active_out};
            if (pending_readings.size() == 0) begin
                fault_count++;
                if (fault_count <= SHOW_LIMIT)
                    $display("%0t: reading with no update pending: s=%0d m=%0d h=%0d",
                             $time, seen.clock_seconds, seen.clock_minutes,
                             seen.clock_hours);
            end else begin
                want = pending_readings.pop_front();
                if (seen !== want) begin
                    fault_count++;
                    if (fault_count <= SHOW_LIMIT)
                        $display("%0t: reading mismatch, expected s=%0d m=%0d h=%0d ", $time,
                                 want.clock_seconds, want.clock_minutes, want.clock_hours,
                                 "avg=%0d win=%0d act=%0d, got s=%0d m=%0d h=%0d ",
                                 want.average_rate, want.window_rate, want.active_out,
                                 seen.clock_seconds, seen.clock_minutes, seen.clock_hours,
                                 "avg=%0d win=%0d act=%0d",
                                 seen.average_rate, seen.window_rate, seen.active_out);
                end
            end
        end
        quiet_cycles = beat ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [TIME_W-1:0]  t_now;
        logic [COUNT_W-1:0] c_now;
        int unsigned        roll;
        int unsigned        back;
        fault_count  = 0;
        quiet_cycles = 0;
        calm         = 1'b0;
        ring_last    = 0;
        warmup_cfg   = WARMUP_RESET;
        foreach (ring_counts[i]) ring_counts[i] = '0;

        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_wdata            <= '0;
        upd_if.valid           <= 1'b0;
        upd_if.elapsed_seconds <= '0;
        upd_if.done_count      <= '0;
        upd_if.active_workers  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (update_table[i]) begin
            if (update_table[i].warmup != NO_CHANGE)
                load_warmup(update_table[i].warmup[WARMUP_W-1:0]);
            send_update(update_table[i].elapsed, update_table[i].count,
                        update_table[i].active, update_table[i].typed,
                        update_table[i].want);
        end

        // random phases: mostly a clock ticking a few seconds per beat
        t_now = '0;
        c_now = '0;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       load_warmup(WARMUP_W'($urandom_range(0, 30)));
                1:       load_warmup(8'd255);
                2:       load_warmup(8'd0);
                default: load_warmup(WARMUP_W'($urandom_range(0, 255)));
            endcase
            calm = (p == 2);
            if (p == 0) begin
                t_now = '0;
                c_now = '0;
            end
            for (int n = 0; n < PHASE_BEATS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    back  = $urandom_range(1, 700);
                    t_now = t_now - ((t_now < back) ? t_now : back);
                end else if (roll < 5) begin
                    t_now = t_now + $urandom_range(600, 100000);
                end else if (roll < 7) begin
                    t_now = $urandom;
                end else if (roll >= 12) begin
                    t_now = t_now + $urandom_range(1, 8);
                end
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    c_now = c_now - COUNT_W'($urandom_range(1, 1000));
                else if (roll < 8)
                    c_now = COUNT_W'($urandom);
                else
                    c_now = c_now + COUNT_W'($urandom_range(0, 40));
                send_update(t_now, c_now, ACT_W'($urandom), 1'b0, '0);
            end
        end

        calm = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
